// ----- rtl/core/alm_pkg.sv -----
// ----------------------------------------------------------------------------
// Alarm table package
// Sizes, command and status codes, and the structs shared by the alarm
// table core and its storage units.
// ----------------------------------------------------------------------------
package alm_pkg;

    // Store depths
    localparam int ACTIVE_DEPTH  = 16;
    localparam int HISTORY_DEPTH = 32;

    // Derived index and count widths
    localparam int ACT_AW  = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int ACT_CW  = $clog2(ACTIVE_DEPTH + 1);
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int HIST_CW = $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W   = (ACT_CW > HIST_CW) ? ACT_CW : HIST_CW;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int MAXC_W = 8;
    localparam int ST_W   = 3;
    localparam int RCNT_W = 6;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RAISE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_ACT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RD_HIST = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_PARAM = 3'd1;
    localparam logic [ST_W-1:0] ST_BUSY  = 3'd2;
    localparam logic [ST_W-1:0] ST_STATE = 3'd3;
    localparam logic [ST_W-1:0] ST_CMD   = 3'd4;

    // Legal alarm id range
    localparam logic [ID_W-1:0] ID_LOW  = 16'd1;
    localparam logic [ID_W-1:0] ID_HIGH = 16'd6;

    // Event kinds
    localparam logic KIND_RAISED  = 1'b0;
    localparam logic KIND_CLEARED = 1'b1;

    // Active table write port
    typedef struct packed {
        logic              we;
        logic [ACT_AW-1:0] addr;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } t_act_wr;

    // One history entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              kind;
        logic [TIME_W-1:0] stamp;
    } t_hist_ent;

    // History ring write port
    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] addr;
        t_hist_ent          ent;
    } t_hist_wr;

    // One result transaction
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              rec_valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
        logic              kind;
        logic [RCNT_W-1:0] cnt;
        logic              last;
    } t_item;

    function automatic t_item status_item(input logic [ST_W-1:0] st,
                                          input logic [RCNT_W-1:0] cnt);
        t_item it;
        it           = '0;
        it.status    = st;
        it.cnt       = cnt;
        it.last      = 1'b1;
        return it;
    endfunction

    function automatic t_item record_item(input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] stamp,
                                          input logic kind);
        t_item it;
        it           = '0;
        it.status    = ST_OK;
        it.rec_valid = 1'b1;
        it.id        = id;
        it.stamp     = stamp;
        it.kind      = kind;
        return it;
    endfunction

endpackage

// ----- rtl/core/alarm_table_with_history_log_core.sv -----
// Invalid commands, rejects and start/stop while running answer in the cycle after accept.
// Raise and clear walk the active table one entry per cycle; a clear moves
// the later entries down after the match, a duplicate raise stops at the match.
// Readouts: each history record is issued, then emitted (registered memory read).
// One transaction at a time; busy drops in the cycle of the last result, results never stall.
// Synchronous active-low reset clears run flag, counts and write pointer; stores need no clear.
// ----------------------------------------------------------------------------
// Alarm table with history log
// Sequencer around the active table walk and the history ring: command
// decode, search, compaction, append/log and readouts.
// ----------------------------------------------------------------------------
module alarm_table_with_history_log_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [alm_pkg::CMD_W-1:0]     i_cmd,
    input  logic [alm_pkg::ID_W-1:0]      i_alarm_id,
    input  logic [alm_pkg::TIME_W-1:0]    i_event_time,
    input  logic [alm_pkg::MAXC_W-1:0]    i_max_count,
    output logic                          o_valid,
    output logic [alm_pkg::ST_W-1:0]      o_status,
    output logic                          o_record_valid,
    output logic [alm_pkg::ID_W-1:0]      o_rec_alarm_id,
    output logic [alm_pkg::TIME_W-1:0]    o_rec_time,
    output logic                          o_rec_kind,
    output logic [alm_pkg::RCNT_W-1:0]    o_returned_count,
    output logic                          o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RD_ACT,
        S_H_ISSUE,
        S_H_EMIT
    } t_state;

    t_state                          r_state;
    logic                            r_running;
    logic [alm_pkg::ACT_CW-1:0]      r_act_cnt;
    logic [alm_pkg::HIST_AW-1:0]     r_hist_wptr;
    logic [alm_pkg::HIST_CW-1:0]     r_hist_cnt;
    logic [alm_pkg::CMD_W-1:0]       r_cmd;
    logic [alm_pkg::ID_W-1:0]        r_id;
    logic [alm_pkg::TIME_W-1:0]      r_stamp;
    logic [alm_pkg::CNT_W-1:0]       r_idx;
    logic [alm_pkg::CNT_W-1:0]       r_n;
    logic                            r_trunc;
    logic [alm_pkg::HIST_AW-1:0]     r_hptr;
    logic                            r_valid;
    alm_pkg::t_item                  r_out;

    logic [alm_pkg::CNT_W-1:0]       idx_nxt;
    logic [alm_pkg::CNT_W-1:0]       act_cnt_ext;
    logic                            scan_end;
    logic                            shift_more;
    logic                            act_full;
    logic                            do_append;
    logic                            do_clear_log;
    logic [alm_pkg::ACT_AW-1:0]      act_raddr;
    logic [alm_pkg::ID_W-1:0]        act_rd_id;
    logic [alm_pkg::TIME_W-1:0]      act_rd_stamp;
    logic                            act_match;
    alm_pkg::t_act_wr                act_wr;
    alm_pkg::t_hist_wr               hist_wr;
    alm_pkg::t_hist_ent              hist_rd;
    logic [alm_pkg::HIST_AW-1:0]     wptr_nxt;
    logic [alm_pkg::HIST_AW-1:0]     hptr_nxt;
    logic [alm_pkg::MAXC_W-1:0]      sel_cnt;
    logic                            rd_trunc;
    logic [alm_pkg::MAXC_W-1:0]      rd_n;
    logic [alm_pkg::HIST_CW-1:0]     wptr_ext;
    logic [alm_pkg::HIST_CW-1:0]     hn;
    logic [alm_pkg::HIST_CW-1:0]     hstart;

    // Walk control
    assign idx_nxt     = r_idx + 1'b1;
    assign act_cnt_ext = alm_pkg::CNT_W'(r_act_cnt);
    assign scan_end    = (r_idx >= act_cnt_ext);
    assign shift_more  = (idx_nxt < act_cnt_ext);
    assign act_full    = (r_act_cnt >= alm_pkg::ACT_CW'(alm_pkg::ACTIVE_DEPTH));
    assign act_raddr   = (r_state == S_SHIFT) ? idx_nxt[alm_pkg::ACT_AW-1:0]
                                              : r_idx[alm_pkg::ACT_AW-1:0];

    assign do_append    = (r_state == S_SEARCH) && scan_end &&
                          (r_cmd == alm_pkg::CMD_RAISE) && !act_full;
    assign do_clear_log = (r_state == S_SEARCH) && !scan_end && act_match &&
                          (r_cmd == alm_pkg::CMD_CLEAR);

    // Active table write: append at the end, or move entry down one slot
    always_comb begin
        act_wr.we    = do_append || ((r_state == S_SHIFT) && shift_more);
        act_wr.addr  = do_append ? r_act_cnt[alm_pkg::ACT_AW-1:0]
                                 : r_idx[alm_pkg::ACT_AW-1:0];
        act_wr.id    = do_append ? r_id : act_rd_id;
        act_wr.stamp = do_append ? r_stamp : act_rd_stamp;
    end

    // History log write
    always_comb begin
        hist_wr.we        = do_append || do_clear_log;
        hist_wr.addr      = r_hist_wptr;
        hist_wr.ent.id    = r_id;
        hist_wr.ent.kind  = do_clear_log ? alm_pkg::KIND_CLEARED : alm_pkg::KIND_RAISED;
        hist_wr.ent.stamp = r_stamp;
    end

    // Ring pointer wrap
    assign wptr_nxt = (r_hist_wptr == alm_pkg::HIST_AW'(alm_pkg::HISTORY_DEPTH - 1))
                      ? '0 : r_hist_wptr + 1'b1;
    assign hptr_nxt = (r_hptr == alm_pkg::HIST_AW'(alm_pkg::HISTORY_DEPTH - 1))
                      ? '0 : r_hptr + 1'b1;

    // Readout length and history start slot
    assign sel_cnt  = (i_cmd == alm_pkg::CMD_RD_ACT) ? alm_pkg::MAXC_W'(r_act_cnt)
                                                     : alm_pkg::MAXC_W'(r_hist_cnt);
    assign rd_trunc = (sel_cnt > i_max_count);
    assign rd_n     = rd_trunc ? i_max_count : sel_cnt;
    assign wptr_ext = alm_pkg::HIST_CW'(r_hist_wptr);
    assign hn       = rd_n[alm_pkg::HIST_CW-1:0];
    assign hstart   = (wptr_ext >= hn) ? (wptr_ext - hn)
                    : (wptr_ext + alm_pkg::HIST_CW'(alm_pkg::HISTORY_DEPTH) - hn);

    alm_act u_act (
        .i_clk      (i_clk),
        .i_wr       (act_wr),
        .i_raddr    (act_raddr),
        .i_key      (r_id),
        .o_rd_id    (act_rd_id),
        .o_rd_stamp (act_rd_stamp),
        .o_match    (act_match)
    );

    alm_hist u_hist (
        .i_clk   (i_clk),
        .i_wr    (hist_wr),
        .i_ren   (r_state == S_H_ISSUE),
        .i_raddr (r_hptr),
        .o_rd    (hist_rd)
    );

    // Sequencer, stores' bookkeeping and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_act_cnt   <= '0;
            r_hist_wptr <= '0;
            r_hist_cnt  <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= 1'b0;

            // History bookkeeping on every logged event
            if (hist_wr.we) begin
                r_hist_wptr <= wptr_nxt;
                if (r_hist_cnt < alm_pkg::HIST_CW'(alm_pkg::HISTORY_DEPTH)) begin
                    r_hist_cnt <= r_hist_cnt + 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd;
                        r_id    <= i_alarm_id;
                        r_stamp <= i_event_time;
                        r_idx   <= '0;
                        r_n     <= rd_n[alm_pkg::CNT_W-1:0];
                        r_trunc <= rd_trunc;
                        r_hptr  <= hstart[alm_pkg::HIST_AW-1:0];
                        if (i_cmd > alm_pkg::CMD_RD_HIST) begin
                            r_valid <= 1'b1;
                            r_out   <= alm_pkg::status_item(alm_pkg::ST_CMD, '0);
                        end else if (!r_running) begin
                            // Idle: start/stop are silent, everything else rejected
                            if (i_cmd == alm_pkg::CMD_START) begin
                                r_running <= 1'b1;
                            end else if (i_cmd != alm_pkg::CMD_STOP) begin
                                r_valid <= 1'b1;
                                r_out   <= alm_pkg::status_item(alm_pkg::ST_STATE, '0);
                            end
                        end else begin
                            unique case (i_cmd)
                                alm_pkg::CMD_START: begin
                                    r_valid <= 1'b1;
                                    r_out   <= alm_pkg::status_item(alm_pkg::ST_OK, '0);
                                end
                                alm_pkg::CMD_STOP: begin
                                    r_running <= 1'b0;
                                    r_valid   <= 1'b1;
                                    r_out     <= alm_pkg::status_item(alm_pkg::ST_OK, '0);
                                end
                                alm_pkg::CMD_RAISE: begin
                                    if (i_alarm_id < alm_pkg::ID_LOW ||
                                        i_alarm_id > alm_pkg::ID_HIGH) begin
                                        r_valid <= 1'b1;
                                        r_out   <= alm_pkg::status_item(alm_pkg::ST_PARAM,
                                                                        '0);
                                    end else begin
                                        r_state <= S_SEARCH;
                                    end
                                end
                                alm_pkg::CMD_CLEAR: begin
                                    r_state <= S_SEARCH;
                                end
                                alm_pkg::CMD_RD_ACT, alm_pkg::CMD_RD_HIST: begin
                                    if (i_max_count == '0) begin
                                        r_valid <= 1'b1;
                                        r_out   <= alm_pkg::status_item(alm_pkg::ST_PARAM,
                                                                        '0);
                                    end else if (i_cmd == alm_pkg::CMD_RD_ACT) begin
                                        r_state <= S_RD_ACT;
                                    end else begin
                                        r_state <= S_H_ISSUE;
                                    end
                                end
                                default: begin
                                    r_valid <= 1'b1;
                                    r_out   <= alm_pkg::status_item(alm_pkg::ST_CMD, '0);
                                end
                            endcase
                        end
                    end
                end

                // Linear search for the id, one entry per cycle
                S_SEARCH: begin
                    if (scan_end) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_cmd == alm_pkg::CMD_CLEAR) begin
                            r_out <= alm_pkg::status_item(alm_pkg::ST_STATE, '0);
                        end else if (act_full) begin
                            r_out <= alm_pkg::status_item(alm_pkg::ST_BUSY, '0);
                        end else begin
                            r_act_cnt <= r_act_cnt + 1'b1;
                            r_out     <= alm_pkg::status_item(alm_pkg::ST_OK, '0);
                        end
                    end else if (act_match) begin
                        if (r_cmd == alm_pkg::CMD_CLEAR) begin
                            r_state <= S_SHIFT;
                        end else begin
                            r_valid <= 1'b1;
                            r_out   <= alm_pkg::status_item(alm_pkg::ST_BUSY, '0);
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= idx_nxt;
                    end
                end

                // Close the gap left by the cleared entry
                S_SHIFT: begin
                    if (shift_more) begin
                        r_idx <= idx_nxt;
                    end else begin
                        r_act_cnt <= r_act_cnt - 1'b1;
                        r_valid   <= 1'b1;
                        r_out     <= alm_pkg::status_item(alm_pkg::ST_OK, '0);
                        r_state   <= S_IDLE;
                    end
                end

                // Active readout, one record per cycle, then status
                S_RD_ACT: begin
                    r_valid <= 1'b1;
                    if (r_idx == r_n) begin
                        r_out   <= alm_pkg::status_item(
                                       r_trunc ? alm_pkg::ST_BUSY : alm_pkg::ST_OK,
                                       alm_pkg::RCNT_W'(r_n));
                        r_state <= S_IDLE;
                    end else begin
                        r_out <= alm_pkg::record_item(act_rd_id, act_rd_stamp,
                                                      alm_pkg::KIND_RAISED);
                        r_idx <= idx_nxt;
                    end
                end

                // History readout: issue read, then emit the registered entry
                S_H_ISSUE: begin
                    if (r_idx == r_n) begin
                        r_valid <= 1'b1;
                        r_out   <= alm_pkg::status_item(
                                       r_trunc ? alm_pkg::ST_BUSY : alm_pkg::ST_OK,
                                       alm_pkg::RCNT_W'(r_n));
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_H_EMIT;
                    end
                end

                S_H_EMIT: begin
                    r_valid <= 1'b1;
                    r_out   <= alm_pkg::record_item(hist_rd.id, hist_rd.stamp,
                                                    hist_rd.kind);
                    r_hptr  <= hptr_nxt;
                    r_idx   <= idx_nxt;
                    r_state <= S_H_ISSUE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Ports
    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_out.status;
    assign o_record_valid   = r_out.rec_valid;
    assign o_rec_alarm_id   = r_out.id;
    assign o_rec_time       = r_out.stamp;
    assign o_rec_kind       = r_out.kind;
    assign o_returned_count = r_out.cnt;
    assign o_last           = r_out.last;

endmodule

// ----- rtl/core/alm_act.sv -----
// ----------------------------------------------------------------------------
// Active alarm table
// Ordered id/time table with one write port, one indexed read port and the
// shared id comparator used by the search walk.
// ----------------------------------------------------------------------------
module alm_act (
    input  logic                          i_clk,
    input  alm_pkg::t_act_wr              i_wr,
    input  logic [alm_pkg::ACT_AW-1:0]    i_raddr,
    input  logic [alm_pkg::ID_W-1:0]      i_key,
    output logic [alm_pkg::ID_W-1:0]      o_rd_id,
    output logic [alm_pkg::TIME_W-1:0]    o_rd_stamp,
    output logic                          o_match
);

    logic [alm_pkg::ID_W-1:0]   r_ids    [alm_pkg::ACTIVE_DEPTH];
    logic [alm_pkg::TIME_W-1:0] r_stamps [alm_pkg::ACTIVE_DEPTH];

    // Table write (append or compaction move)
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_ids[i_wr.addr]    <= i_wr.id;
            r_stamps[i_wr.addr] <= i_wr.stamp;
        end
    end

    // Indexed read and id compare
    assign o_rd_id    = r_ids[i_raddr];
    assign o_rd_stamp = r_stamps[i_raddr];
    assign o_match    = (o_rd_id == i_key);

endmodule

// ----- rtl/core/alm_hist.sv -----
// ----------------------------------------------------------------------------
// History ring memory
// Single-write, single-read event memory with registered read data.
// ----------------------------------------------------------------------------
module alm_hist (
    input  logic                          i_clk,
    input  alm_pkg::t_hist_wr             i_wr,
    input  logic                          i_ren,
    input  logic [alm_pkg::HIST_AW-1:0]   i_raddr,
    output alm_pkg::t_hist_ent            o_rd
);

    alm_pkg::t_hist_ent r_mem [alm_pkg::HISTORY_DEPTH];
    alm_pkg::t_hist_ent r_rd;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.ent;
        end
        if (i_ren) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rd = r_rd;

endmodule

// ----- rtl/core/alm_chk.sv -----
// ----------------------------------------------------------------------------
// Alarm table port checker
// Port-level properties of the result stream, bound to the core.
// ----------------------------------------------------------------------------
module alm_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [alm_pkg::CMD_W-1:0]     i_cmd,
    input logic                          o_valid,
    input logic [alm_pkg::ST_W-1:0]      o_status,
    input logic                          o_record_valid,
    input logic [alm_pkg::RCNT_W-1:0]    o_returned_count,
    input logic                          o_last
);

    // A record transaction never closes the command
    a_rec_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_valid) |-> !o_last)
        else $error("record transaction marked last");

    // A status transaction always closes the command
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_record_valid) |-> o_last)
        else $error("status transaction not marked last");

    // Records carry success and no count
    a_rec_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_valid) |->
            (o_status == alm_pkg::ST_OK && o_returned_count == '0))
        else $error("record transaction with status or count");

    // Records are only produced while a readout is in progress
    a_rec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_valid) |-> busy)
        else $error("record transaction while not busy");

    // An undefined command is answered in the next cycle
    a_bad_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd > alm_pkg::CMD_RD_HIST)) |=>
            (o_valid && o_status == alm_pkg::ST_CMD && o_last))
        else $error("undefined command not rejected");

endmodule

bind alarm_table_with_history_log_core alm_chk u_alm_chk (.*);
